[rtl/core/text_console_cursor_engine_macros.svh]
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_MACROS_SVH

// same-cycle implication
`define TCCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcce check failed");

// next-cycle implication
`define TCCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcce check failed");

`endif

[rtl/core/tcce_pkg.sv]
package tcce_pkg;

    localparam int COL_W       = 9;
    localparam int ROW_W       = 8;
    localparam int CODE_W      = 8;
    localparam int COLOUR_W    = 8;
    localparam int FONT_W      = 3;
    localparam int GW_W        = 4;
    localparam int GH_W        = 5;
    localparam int PC_W        = 5;
    localparam int MAX_RESULTS = 4;
    localparam int LINE_GAP    = 2;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_COL,
        OP_NEWLINE,
        OP_WRAP,
        OP_PRINT,
        OP_BS_ERASE,
        OP_BS_UP,
        OP_MOD_COL,
        OP_MOD_ROW,
        OP_MOD_WW,
        OP_STAGE_TAB,
        OP_TAB_ADV,
        OP_PUSH,
        OP_FINISH
    } op_t;

    typedef enum logic [3:0] {
        C_NEXT,
        C_ALWAYS,
        C_IDLE,
        C_CMD1,
        C_TAB,
        C_BS,
        C_NOT_NL,
        C_NO_FIT,
        C_BS_UP,
        C_AT_ORIGIN,
        C_TAB_DONE,
        C_NO_PUSH,
        C_NO_STAGE
    } cond_t;

    typedef struct packed {
        logic accept;
        logic cmd1;
        logic is_tab;
        logic is_bs;
        logic not_nl;
        logic no_fit;
        logic bs_up;
        logic at_origin;
        logic tab_done;
        logic no_push;
        logic no_stage;
    } flags_t;

    typedef struct packed {
        op_t             op;
        cond_t           cond;
        logic [PC_W-1:0] target;
        logic            ready;
    } ctrl_t;

endpackage

[rtl/core/tcce_modulo.sv]
module tcce_modulo
    import tcce_pkg::*;
#(
    parameter int WIDTH = 9
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             ack,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DONE
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] dvd_reg, dvd_next;
    logic [WIDTH-1:0] dvs_reg, dvs_next;
    logic [WIDTH:0]   shifted;

    assign shifted = {rem_reg, dvd_reg[WIDTH-1]};

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        dvd_next   = dvd_reg;
        dvs_next   = dvs_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req)
                begin
                    dvd_next = dividend;
                    dvs_next = divisor;
                    cnt_next = '0;
                    // zero divisor leaves the value unreduced
                    if (divisor == '0)
                    begin
                        rem_next   = dividend;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        rem_next   = '0;
                        state_next = S_RUN;
                    end
                end
            end
            S_RUN:
            begin
                if (shifted >= {1'b0, dvs_reg})
                begin
                    rem_next = WIDTH'(shifted - {1'b0, dvs_reg});
                end
                else
                begin
                    rem_next = shifted[WIDTH-1:0];
                end
                dvd_next = {dvd_reg[WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WIDTH - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
    end

    assign ack       = (state_reg == S_DONE);
    assign remainder = rem_reg;

endmodule

[rtl/core/tcce_sequencer.sv]
module tcce_sequencer
    import tcce_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    input  logic   stall,
    output ctrl_t  ctrl
);

    localparam logic [PC_W-1:0] L_IDLE   = PC_W'(0);
    localparam logic [PC_W-1:0] L_PRINT  = PC_W'(6);
    localparam logic [PC_W-1:0] L_WRAP   = PC_W'(8);
    localparam logic [PC_W-1:0] L_FINISH = PC_W'(9);
    localparam logic [PC_W-1:0] L_CMD    = PC_W'(10);
    localparam logic [PC_W-1:0] L_BS     = PC_W'(12);
    localparam logic [PC_W-1:0] L_UP     = PC_W'(15);
    localparam logic [PC_W-1:0] L_TAB    = PC_W'(17);
    localparam logic [PC_W-1:0] L_MOD    = PC_W'(20);
    localparam logic [PC_W-1:0] L_ADV    = PC_W'(24);

    logic [PC_W-1:0] pc_reg, pc_next;
    logic            take;

    function automatic ctrl_t mk(input op_t op, input cond_t cond,
                                 input logic [PC_W-1:0] target, input logic ready);
        ctrl_t w;
        w.op     = op;
        w.cond   = cond;
        w.target = target;
        w.ready  = ready;
        return w;
    endfunction

    function automatic ctrl_t rom_word(input logic [PC_W-1:0] addr);
        ctrl_t w;
        unique case (addr)
            PC_W'(0):  w = mk(OP_NOP,       C_IDLE,      L_IDLE,   1'b1);
            PC_W'(1):  w = mk(OP_NOP,       C_CMD1,      L_CMD,    1'b0);
            PC_W'(2):  w = mk(OP_NOP,       C_TAB,       L_TAB,    1'b0);
            PC_W'(3):  w = mk(OP_NOP,       C_BS,        L_BS,     1'b0);
            PC_W'(4):  w = mk(OP_NOP,       C_NOT_NL,    L_PRINT,  1'b0);
            PC_W'(5):  w = mk(OP_NEWLINE,   C_ALWAYS,    L_WRAP,   1'b0);
            PC_W'(6):  w = mk(OP_NOP,       C_NO_FIT,    L_WRAP,   1'b0);
            PC_W'(7):  w = mk(OP_PRINT,     C_NEXT,      L_IDLE,   1'b0);
            PC_W'(8):  w = mk(OP_WRAP,      C_NEXT,      L_IDLE,   1'b0);
            PC_W'(9):  w = mk(OP_FINISH,    C_ALWAYS,    L_IDLE,   1'b0);
            PC_W'(10): w = mk(OP_LOAD_COL,  C_NEXT,      L_IDLE,   1'b0);
            PC_W'(11): w = mk(OP_WRAP,      C_ALWAYS,    L_FINISH, 1'b0);
            PC_W'(12): w = mk(OP_NOP,       C_BS_UP,     L_UP,     1'b0);
            PC_W'(13): w = mk(OP_NOP,       C_AT_ORIGIN, L_WRAP,   1'b0);
            PC_W'(14): w = mk(OP_BS_ERASE,  C_ALWAYS,    L_WRAP,   1'b0);
            PC_W'(15): w = mk(OP_MOD_WW,    C_NEXT,      L_IDLE,   1'b0);
            PC_W'(16): w = mk(OP_BS_UP,     C_ALWAYS,    L_FINISH, 1'b0);
            PC_W'(17): w = mk(OP_NOP,       C_TAB_DONE,  L_WRAP,   1'b0);
            PC_W'(18): w = mk(OP_NOP,       C_NO_PUSH,   L_MOD,    1'b0);
            PC_W'(19): w = mk(OP_PUSH,      C_NEXT,      L_IDLE,   1'b0);
            PC_W'(20): w = mk(OP_MOD_COL,   C_NEXT,      L_IDLE,   1'b0);
            PC_W'(21): w = mk(OP_MOD_ROW,   C_NEXT,      L_IDLE,   1'b0);
            PC_W'(22): w = mk(OP_NOP,       C_NO_STAGE,  L_ADV,    1'b0);
            PC_W'(23): w = mk(OP_STAGE_TAB, C_NEXT,      L_IDLE,   1'b0);
            PC_W'(24): w = mk(OP_TAB_ADV,   C_NEXT,      L_IDLE,   1'b0);
            PC_W'(25): w = mk(OP_WRAP,      C_ALWAYS,    L_TAB,    1'b0);
            default:   w = mk(OP_NOP,       C_ALWAYS,    L_IDLE,   1'b0);
        endcase
        return w;
    endfunction

    assign ctrl = rom_word(pc_reg);

    always_comb
    begin
        unique case (ctrl.cond)
            C_NEXT:      take = 1'b0;
            C_ALWAYS:    take = 1'b1;
            C_IDLE:      take = !flags.accept;
            C_CMD1:      take = flags.cmd1;
            C_TAB:       take = flags.is_tab;
            C_BS:        take = flags.is_bs;
            C_NOT_NL:    take = flags.not_nl;
            C_NO_FIT:    take = flags.no_fit;
            C_BS_UP:     take = flags.bs_up;
            C_AT_ORIGIN: take = flags.at_origin;
            C_TAB_DONE:  take = flags.tab_done;
            C_NO_PUSH:   take = flags.no_push;
            C_NO_STAGE:  take = flags.no_stage;
            default:     take = 1'b1;
        endcase
    end

    always_comb
    begin
        pc_next = pc_reg;
        if (!stall)
        begin
            pc_next = take ? ctrl.target : pc_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= L_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

[rtl/core/text_console_cursor_engine.sv]
// text console cursor engine
// s_* carries one beat per character (tuser[0] = command, 0 write character,
// 1 set cursor column after an outside rescan); m_* carries the draw results,
// one to four beats per character, tlast on the final beat of each character.
// cfg_we/cfg_index/cfg_data write the font, window, origin and colour
// registers; write them only while the block is idle.
// a small microcode program steps through each character one control word per
// cycle unless the modulo unit or a full output register stalls it; the tab
// and line-up steps use the shared 9-bit restoring modulo unit.
// s_tready is high only while the program sits at its idle step.
// results leave through an output register, so the next character is taken
// while the last beat still waits; a stall on m_tready holds the program at
// its next emit step and nothing is lost.
// reset puts the cursor at 0,0 and the registers at font 2, window 320x200,
// origin 0,0, text colour 15, background colour 0.
`include "text_console_cursor_engine_macros.svh"

module text_console_cursor_engine
    import tcce_pkg::*;
#(
    parameter int TAB_SPACES = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // char_code, new_column
    input  logic [0:0]  s_tuser,   // command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // draw_x, draw_y, glyph, draw_colour, cursor_x, cursor_y
    output logic [1:0]  m_tuser,   // draw_kind
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [8:0]  cfg_data
);

    localparam int TAB_CNT_W = $clog2(TAB_SPACES + 1);
    localparam int SUM_W     = COL_W + 1;
    localparam int FONT_N    = 7;

    localparam logic [GW_W-1:0] GLYPH_W [FONT_N] = '{4'd4, 4'd5, 4'd6, 4'd7, 4'd8, 4'd10, 4'd12};
    localparam logic [GH_W-1:0] GLYPH_H [FONT_N] = '{5'd6, 5'd12, 5'd8, 5'd12, 5'd12, 5'd18,
                                                     5'd16};

    localparam logic [CODE_W-1:0] CODE_BS         = 8'd8;
    localparam logic [CODE_W-1:0] CODE_TAB        = 8'd9;
    localparam logic [CODE_W-1:0] CODE_NL         = 8'd10;
    localparam logic [CODE_W-1:0] FIRST_PRINTABLE = 8'd32;
    localparam logic [CODE_W-1:0] GLYPH_SPACE     = 8'd32;

    typedef enum logic [1:0] {
        KIND_NONE,
        KIND_GLYPH,
        KIND_ERASE,
        KIND_RESCAN
    } kind_t;

    typedef enum logic [2:0] {
        REG_FONT,
        REG_WIDTH,
        REG_HEIGHT,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_TEXT,
        REG_BACK
    } cfg_reg_t;

    // configuration
    logic [FONT_W-1:0]   font_reg;
    logic [COL_W-1:0]    ww_reg;
    logic [ROW_W-1:0]    wh_reg;
    logic [COL_W-1:0]    ox_reg;
    logic [ROW_W-1:0]    oy_reg;
    logic [COLOUR_W-1:0] text_reg;
    logic [COLOUR_W-1:0] back_reg;

    // cursor and control
    logic [COL_W-1:0]     col_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [TAB_CNT_W-1:0] tab_cnt_reg;
    logic                 stg_valid_reg;
    logic                 m_valid_reg;

    // payload
    logic                cmd_reg;
    logic [CODE_W-1:0]   char_reg;
    logic [COL_W-1:0]    newcol_reg;
    logic [COL_W-1:0]    x_reg;
    logic [ROW_W-1:0]    y_reg;
    logic [COL_W-1:0]    wmod_reg;
    kind_t               stg_kind_reg;
    logic [COL_W-1:0]    stg_x_reg;
    logic [ROW_W-1:0]    stg_y_reg;
    logic [CODE_W-1:0]   stg_glyph_reg;
    logic [COLOUR_W-1:0] stg_colour_reg;
    kind_t               m_kind_reg;
    logic [COL_W-1:0]    m_x_reg;
    logic [ROW_W-1:0]    m_y_reg;
    logic [CODE_W-1:0]   m_glyph_reg;
    logic [COLOUR_W-1:0] m_colour_reg;
    logic [COL_W-1:0]    m_cx_reg;
    logic [ROW_W-1:0]    m_cy_reg;
    logic                m_last_reg;

    ctrl_t  ctrl;
    flags_t flags;
    logic   stall;
    logic   accept;

    logic [FONT_W-1:0] font_eff;
    logic [GW_W-1:0]   kw;
    logic [GH_W-1:0]   kh;

    logic [SUM_W-1:0] col_kw;
    logic [SUM_W-1:0] lim_x;
    logic [SUM_W-1:0] lim_y;
    logic [SUM_W-1:0] row_2kh;
    logic [SUM_W-1:0] row_kh2;
    logic             wrap_hit;
    logic             wrap_down;
    logic             print_fit;
    logic [ROW_W-1:0] row_down;
    logic [ROW_W-1:0] row_up;
    logic [COL_W-1:0] col_adv;
    logic [COL_W-1:0] col_back;
    logic [COL_W-1:0] scan_col;

    logic             mod_req;
    logic             mod_ack;
    logic [COL_W-1:0] mod_a;
    logic [COL_W-1:0] mod_b;
    logic [COL_W-1:0] mod_rem;

    logic is_emit;
    logic out_free;
    logic emit;

    // font index wraps at seven
    assign font_eff = (font_reg == FONT_W'(FONT_N)) ? '0 : font_reg;
    assign kw       = GLYPH_W[font_eff];
    assign kh       = GLYPH_H[font_eff];

    assign col_kw    = {1'b0, col_reg} + SUM_W'(kw);
    assign lim_x     = {1'b0, ww_reg} + {1'b0, ox_reg};
    assign lim_y     = SUM_W'(wh_reg) + SUM_W'(oy_reg);
    assign row_2kh   = SUM_W'(row_reg) + SUM_W'({kh, 1'b0});
    assign row_kh2   = SUM_W'(row_reg) + SUM_W'(kh) + SUM_W'(LINE_GAP);
    assign wrap_hit  = (col_kw >= lim_x);
    assign wrap_down = (row_2kh < lim_y);
    assign print_fit = (col_kw < lim_x) && (row_kh2 < lim_y);
    assign row_down  = row_reg + ROW_W'(kh) + ROW_W'(LINE_GAP);
    assign row_up    = row_reg - ROW_W'(kh) - ROW_W'(LINE_GAP);
    assign col_adv   = col_reg + COL_W'(kw);
    assign col_back  = col_reg - COL_W'(kw);
    assign scan_col  = ww_reg - COL_W'(kw) - wmod_reg;

    assign accept   = s_tvalid && ctrl.ready;
    assign s_tready = ctrl.ready;

    assign flags.accept    = accept;
    assign flags.cmd1      = cmd_reg;
    assign flags.is_tab    = (char_reg == CODE_TAB);
    assign flags.is_bs     = (char_reg == CODE_BS);
    assign flags.not_nl    = (char_reg != CODE_NL);
    assign flags.no_fit    = !((char_reg >= FIRST_PRINTABLE) && print_fit);
    assign flags.bs_up     = (col_reg == ox_reg) && (row_reg > oy_reg);
    assign flags.at_origin = (col_reg == ox_reg);
    assign flags.tab_done  = (tab_cnt_reg == TAB_CNT_W'(TAB_SPACES));
    assign flags.no_push   = (tab_cnt_reg == '0) || (32'(tab_cnt_reg) >= MAX_RESULTS);
    assign flags.no_stage  = (32'(tab_cnt_reg) >= MAX_RESULTS);

    assign mod_req  = (ctrl.op == OP_MOD_COL) || (ctrl.op == OP_MOD_ROW) ||
                      (ctrl.op == OP_MOD_WW);
    assign is_emit  = (ctrl.op == OP_PUSH) || (ctrl.op == OP_FINISH);
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = is_emit && out_free;
    assign stall    = (mod_req && !mod_ack) || (is_emit && !out_free);

    always_comb
    begin
        unique case (ctrl.op)
            OP_MOD_ROW:
            begin
                mod_a = COL_W'(row_reg);
                mod_b = COL_W'(wh_reg);
            end
            OP_MOD_WW:
            begin
                mod_a = ww_reg;
                mod_b = COL_W'(kw);
            end
            default:
            begin
                mod_a = col_reg;
                mod_b = ww_reg;
            end
        endcase
    end

    tcce_modulo #(
        .WIDTH (COL_W)
    ) u_modulo (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mod_req),
        .dividend  (mod_a),
        .divisor   (mod_b),
        .ack       (mod_ack),
        .remainder (mod_rem)
    );

    tcce_sequencer u_sequencer (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .stall (stall),
        .ctrl  (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            font_reg      <= 3'd2;
            ww_reg        <= 9'd320;
            wh_reg        <= 8'd200;
            ox_reg        <= '0;
            oy_reg        <= '0;
            text_reg      <= 8'd15;
            back_reg      <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            tab_cnt_reg   <= '0;
            stg_valid_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tab_cnt_reg <= '0;
            end

            unique case (ctrl.op)
                OP_LOAD_COL:
                begin
                    col_reg <= newcol_reg;
                end
                OP_NEWLINE:
                begin
                    row_reg <= row_down;
                    col_reg <= ox_reg;
                end
                OP_WRAP:
                begin
                    if (wrap_hit)
                    begin
                        col_reg <= ox_reg;
                        if (wrap_down)
                        begin
                            row_reg <= row_down;
                        end
                    end
                end
                OP_PRINT:
                begin
                    col_reg       <= col_adv;
                    stg_valid_reg <= 1'b1;
                end
                OP_BS_ERASE:
                begin
                    col_reg       <= col_back;
                    stg_valid_reg <= 1'b1;
                end
                OP_BS_UP:
                begin
                    col_reg       <= scan_col;
                    row_reg       <= row_up;
                    stg_valid_reg <= 1'b1;
                end
                OP_STAGE_TAB:
                begin
                    stg_valid_reg <= 1'b1;
                end
                OP_TAB_ADV:
                begin
                    col_reg     <= col_adv;
                    tab_cnt_reg <= tab_cnt_reg + 1'b1;
                end
                OP_PUSH, OP_FINISH:
                begin
                    if (emit)
                    begin
                        stg_valid_reg <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase

            if (emit)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_we)
            begin
                case (cfg_reg_t'(cfg_index))
                    REG_FONT:     font_reg <= cfg_data[FONT_W-1:0];
                    REG_WIDTH:    ww_reg   <= cfg_data[COL_W-1:0];
                    REG_HEIGHT:   wh_reg   <= cfg_data[ROW_W-1:0];
                    REG_ORIGIN_X:
                    begin
                        ox_reg  <= cfg_data[COL_W-1:0];
                        col_reg <= cfg_data[COL_W-1:0];
                    end
                    REG_ORIGIN_Y:
                    begin
                        oy_reg  <= cfg_data[ROW_W-1:0];
                        row_reg <= cfg_data[ROW_W-1:0];
                    end
                    REG_TEXT:     text_reg <= cfg_data[COLOUR_W-1:0];
                    REG_BACK:     back_reg <= cfg_data[COLOUR_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg    <= s_tuser[0];
            char_reg   <= s_tdata[CODE_W-1:0];
            newcol_reg <= s_tdata[CODE_W+COL_W-1:CODE_W];
        end

        if (mod_ack)
        begin
            unique case (ctrl.op)
                OP_MOD_COL: x_reg    <= mod_rem;
                OP_MOD_ROW: y_reg    <= mod_rem[ROW_W-1:0];
                OP_MOD_WW:  wmod_reg <= mod_rem;
                default:
                begin
                end
            endcase
        end

        unique case (ctrl.op)
            OP_PRINT:
            begin
                stg_kind_reg   <= KIND_GLYPH;
                stg_x_reg      <= col_reg;
                stg_y_reg      <= row_reg;
                stg_glyph_reg  <= char_reg;
                stg_colour_reg <= text_reg;
            end
            OP_BS_ERASE:
            begin
                stg_kind_reg   <= KIND_ERASE;
                stg_x_reg      <= col_back;
                stg_y_reg      <= row_reg;
                stg_glyph_reg  <= '0;
                stg_colour_reg <= back_reg;
            end
            OP_BS_UP:
            begin
                stg_kind_reg   <= KIND_RESCAN;
                stg_x_reg      <= scan_col;
                stg_y_reg      <= row_up;
                stg_glyph_reg  <= '0;
                stg_colour_reg <= '0;
            end
            OP_STAGE_TAB:
            begin
                stg_kind_reg   <= KIND_GLYPH;
                stg_x_reg      <= x_reg;
                stg_y_reg      <= y_reg;
                stg_glyph_reg  <= GLYPH_SPACE;
                stg_colour_reg <= text_reg;
            end
            default:
            begin
            end
        endcase

        if (emit)
        begin
            // nothing staged means a no-draw beat
            if (stg_valid_reg)
            begin
                m_kind_reg   <= stg_kind_reg;
                m_x_reg      <= stg_x_reg;
                m_y_reg      <= stg_y_reg;
                m_glyph_reg  <= stg_glyph_reg;
                m_colour_reg <= stg_colour_reg;
            end
            else
            begin
                m_kind_reg   <= KIND_NONE;
                m_x_reg      <= '0;
                m_y_reg      <= '0;
                m_glyph_reg  <= '0;
                m_colour_reg <= '0;
            end
            m_cx_reg   <= col_reg;
            m_cy_reg   <= row_reg;
            m_last_reg <= (ctrl.op == OP_FINISH);
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'b0, m_cy_reg, m_cx_reg, m_colour_reg, m_glyph_reg, m_y_reg, m_x_reg};

    `TCCE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `TCCE_ASSERT_IMP(a_ack_in_mod_step, clk, rst_n, mod_ack, mod_req)
    `TCCE_ASSERT_IMP(a_idle_nothing_staged, clk, rst_n, s_tready, !stg_valid_reg)
    `TCCE_ASSERT_IMP(a_push_has_result, clk, rst_n, emit && (ctrl.op == OP_PUSH), stg_valid_reg)

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps

module testbench;
    import tcce_pkg::*;

    localparam int TAB_COUNT = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE_CYCLES = 40;
    localparam int STALL_LIMIT = 3000;
    localparam int MAX_REPORTS = 10;

    localparam logic [7:0] CH_BS = 8'd8;
    localparam logic [7:0] CH_TAB = 8'd9;
    localparam logic [7:0] CH_NL = 8'd10;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic CMD_CHAR = 1'b0;
    localparam logic CMD_SET_COL = 1'b1;

    typedef enum logic [1:0] {
        DRAW_NONE,
        DRAW_GLYPH,
        DRAW_ERASE,
        DRAW_RESCAN
    } draw_kind_t;

    typedef enum logic [2:0] {
        REG_FONT,
        REG_WIDTH,
        REG_HEIGHT,
        REG_ORIGIN_X,
        REG_ORIGIN_Y,
        REG_TEXT_COLOUR,
        REG_BACK_COLOUR,
        REG_SPARE
    } reg_index_t;

    typedef struct packed {
        draw_kind_t kind;
        logic [8:0] x;
        logic [7:0] y;
        logic [7:0] glyph;
        logic [7:0] colour;
        logic [8:0] cx;
        logic [7:0] cy;
        logic       last;
    } draw_t;

    localparam int GLYPH_W [7] = '{4, 5, 6, 7, 8, 10, 12};
    localparam int GLYPH_H [7] = '{6, 12, 8, 12, 12, 18, 16};

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;   // char_code, new_column
    logic [0:0]  s_tuser = '0;   // command
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;        // draw_x, draw_y, glyph, draw_colour, cursor_x, cursor_y
    logic [1:0]  m_tuser;        // draw_kind
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [8:0]  cfg_data = '0;

    // model of the cursor engine
    logic [2:0] reg_font = 3'd2;
    logic [8:0] reg_ww = 9'd320;
    logic [7:0] reg_wh = 8'd200;
    logic [8:0] reg_ox = '0;
    logic [7:0] reg_oy = '0;
    logic [7:0] reg_tc = 8'd15;
    logic [7:0] reg_bc = '0;
    logic [8:0] cur_col = '0;
    logic [7:0] cur_row = '0;

    draw_t step_out [$];
    draw_t pending_draws [$];

    bit rescan_pending = 0;
    bit steady = 0;
    bit hold_req = 0;
    int hold_left = 0;
    int mismatches = 0;
    int chars_sent = 0;
    int beats_checked = 0;
    int reg_writes = 0;
    int rescans = 0;
    int quiet_cycles = 0;
    draw_t got;
    draw_t want;

    text_console_cursor_engine #(.TAB_SPACES(TAB_COUNT)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void add_draw(draw_kind_t k, logic [8:0] x, logic [7:0] y,
                                     logic [7:0] g, logic [7:0] c);
        draw_t d;
        d.kind = k;
        d.x = x;
        d.y = y;
        d.glyph = g;
        d.colour = c;
        d.cx = cur_col;
        d.cy = cur_row;
        d.last = 1'b0;
        step_out.push_back(d);
    endfunction

    function automatic void wrap_cursor(int gw, int gh);
        if (int'(cur_col) + gw - int'(reg_ox) >= int'(reg_ww))
        begin
            cur_col = reg_ox;
            if (int'(cur_row) + 2 * gh - int'(reg_oy) < int'(reg_wh))
                cur_row = 8'(cur_row + gh + LINE_GAP);
        end
    endfunction

    function automatic void predict_draws(logic cmd, logic [7:0] code, logic [8:0] col);
        int f;
        int gw;
        int gh;
        int i;
        logic [8:0] px;
        logic [7:0] py;
        bit up_line;
        draw_t tail;
        f = reg_font % 7;
        gw = GLYPH_W[f];
        gh = GLYPH_H[f];
        up_line = 0;
        step_out.delete();
        if (cmd == CMD_SET_COL)
        begin
            cur_col = col;
            wrap_cursor(gw, gh);
            add_draw(DRAW_NONE, '0, '0, '0, '0);
            rescan_pending = 0;
        end
        else
        begin
            if (code == CH_NL)
            begin
                cur_row = 8'(cur_row + gh + LINE_GAP);
                cur_col = reg_ox;
            end
            if (code == CH_TAB)
            begin
                for (i = 0; i < TAB_COUNT; i++)
                begin
                    px = (reg_ww != 0) ? cur_col % reg_ww : cur_col;
                    py = (reg_wh != 0) ? cur_row % reg_wh : cur_row;
                    cur_col = 9'(cur_col + gw);
                    wrap_cursor(gw, gh);
                    if (step_out.size() < MAX_RESULTS)
                        add_draw(DRAW_GLYPH, px, py, CH_SPACE, reg_tc);
                end
            end
            if (code == CH_BS)
            begin
                if (cur_col == reg_ox && cur_row > reg_oy)
                begin
                    cur_row = 8'(cur_row - gh - LINE_GAP);
                    cur_col = 9'(reg_ww - gw - reg_ww % gw);
                    add_draw(DRAW_RESCAN, cur_col, cur_row, '0, '0);
                    up_line = 1;
                    rescan_pending = 1;
                    rescans++;
                end
                else if (cur_col != reg_ox)
                begin
                    cur_col = 9'(cur_col - gw);
                    add_draw(DRAW_ERASE, cur_col, cur_row, '0, reg_bc);
                end
            end
            if (!up_line)
            begin
                if (code >= CH_SPACE
                    && int'(cur_col) + gw - int'(reg_ox) < int'(reg_ww)
                    && int'(cur_row) + gh + LINE_GAP - int'(reg_oy) < int'(reg_wh))
                begin
                    px = cur_col;
                    py = cur_row;
                    cur_col = 9'(cur_col + gw);
                    add_draw(DRAW_GLYPH, px, py, code, reg_tc);
                end
                wrap_cursor(gw, gh);
                if (step_out.size() == 0)
                    add_draw(DRAW_NONE, '0, '0, '0, '0);
            end
        end
        tail = step_out[step_out.size() - 1];
        tail.cx = cur_col;
        tail.cy = cur_row;
        tail.last = 1'b1;
        step_out[step_out.size() - 1] = tail;
        foreach (step_out[k])
            pending_draws.push_back(step_out[k]);
    endfunction

    task automatic write_reg(input reg_index_t idx, input logic [8:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        reg_writes++;
        case (idx)
            REG_FONT: reg_font = val[2:0];
            REG_WIDTH: reg_ww = val;
            REG_HEIGHT: reg_wh = val[7:0];
            REG_ORIGIN_X:
            begin
                reg_ox = val;
                cur_col = val;
            end
            REG_ORIGIN_Y:
            begin
                reg_oy = val[7:0];
                cur_row = val[7:0];
            end
            REG_TEXT_COLOUR: reg_tc = val[7:0];
            REG_BACK_COLOUR: reg_bc = val[7:0];
            default: ;
        endcase
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_all(input logic [8:0] font, input logic [8:0] ww, input logic [8:0] wh,
                           input logic [8:0] ox, input logic [8:0] oy,
                           input logic [8:0] tc, input logic [8:0] bc);
        write_reg(REG_FONT, font);
        write_reg(REG_WIDTH, ww);
        write_reg(REG_HEIGHT, wh);
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Y, oy);
        write_reg(REG_TEXT_COLOUR, tc);
        write_reg(REG_BACK_COLOUR, bc);
        end_writes();
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] code, input logic [8:0] col);
        if (!steady && $urandom_range(99) < 26)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, col, code};
        do
            @(posedge clk);
        while (!s_tready);
        predict_draws(cmd, code, col);
        chars_sent++;
    endtask

    task automatic send_char(input logic [7:0] code);
        send_item(CMD_CHAR, code, 9'($urandom_range(511)));
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (pending_draws.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // mostly plain text with line breaks, tabs and erases; most rescans get answered
    task automatic send_random_item();
        int r;
        r = $urandom_range(99);
        if (rescan_pending && r < 85)
            send_item(CMD_SET_COL, 8'($urandom_range(255)),
                      9'(reg_ox + $urandom_range(0, reg_ww)));
        else if (r < 55)
            send_char(8'($urandom_range(32, 126)));
        else if (r < 63)
            send_char(CH_NL);
        else if (r < 71)
            send_char(CH_TAB);
        else if (r < 81)
            send_char(CH_BS);
        else if (r < 86)
            send_item(CMD_SET_COL, 8'($urandom_range(255)), 9'($urandom_range(511)));
        else
            send_char(8'($urandom_range(255)));
    endtask

    task automatic random_settings();
        int r;
        logic [8:0] ww;
        logic [8:0] wh;
        r = $urandom_range(99);
        ww = (r < 8) ? 9'($urandom_range(0, 1) ? 511 : $urandom_range(0, 2))
                     : 9'($urandom_range(16, 200));
        r = $urandom_range(99);
        wh = (r < 8) ? 9'($urandom_range(0, 1) ? 255 : $urandom_range(0, 2))
                     : 9'($urandom_range(16, 200));
        write_reg(REG_FONT, 9'($urandom_range(7)));
        write_reg(REG_WIDTH, ww);
        write_reg(REG_HEIGHT, wh);
        if ($urandom_range(3) != 0)
            write_reg(REG_ORIGIN_X, 9'($urandom_range(0, 100)));
        if ($urandom_range(3) != 0)
            write_reg(REG_ORIGIN_Y, 9'($urandom_range(0, 60)));
        write_reg(REG_TEXT_COLOUR, 9'($urandom_range(255)));
        write_reg(REG_BACK_COLOUR, 9'($urandom_range(255)));
        end_writes();
    endtask

    task automatic test_default_text();
        send_char(8'd65);
        send_char(8'hFF);
        send_char(CH_SPACE);
        send_char(CH_TAB);
        send_char(CH_BS);
        send_char(CH_NL);
        send_char(CH_BS);
        send_item(CMD_SET_COL, 8'hFF, 9'h1FF);
        send_item(CMD_SET_COL, 8'h00, 9'h000);
        send_char(8'd0);
        send_char(8'd31);
        send_char(8'h7F);
        wait_idle();
    endtask

    task automatic test_window_extremes();
        // zero window, font index past the table end
        set_all(9'd7, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0);
        send_char(CH_TAB);
        send_char(8'd65);
        send_char(CH_BS);
        wait_idle();
        set_all(9'd6, 9'd511, 9'd255, 9'd319, 9'd199, 9'd255, 9'd255);
        write_reg(REG_SPARE, 9'h1FF);
        end_writes();
        send_char(8'd90);
        send_char(CH_TAB);
        send_char(CH_NL);
        send_char(CH_BS);
        send_item(CMD_SET_COL, 8'h00, 9'd0);
        wait_idle();
        set_all(9'd5, 9'd1, 9'd1, 9'd511, 9'd255, 9'd170, 9'd85);
        send_char(8'd120);
        send_char(CH_TAB);
        send_char(CH_BS);
        wait_idle();
    endtask

    task automatic test_random_text(input int count, input bit no_gaps);
        random_settings();
        steady = no_gaps;
        repeat (count) send_random_item();
        steady = 0;
        wait_idle();
    endtask

    task automatic test_backpressure();
        random_settings();
        hold_req = 1;
        repeat (20) send_random_item();
        wait_idle();
    endtask

    initial
    begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_text();
        test_window_extremes();
        test_random_text(85, 0);
        test_random_text(85, 0);
        test_random_text(85, 1);
        test_backpressure();
        test_random_text(85, 0);
        test_random_text(85, 0);
        test_random_text(65, 0);
        $display("sent %0d characters, checked %0d draw beats, %0d register writes",
                 chars_sent, beats_checked, reg_writes);
        $display("line-up rescans %0d, zero and full window sizes, all fonts", rescans);
        if (mismatches == 0 && pending_draws.size() == 0)
            $display("PASS text_console_cursor_engine");
        else
            $display("FAIL text_console_cursor_engine");
        $finish;
    end

    // draw sink with random stalls and one long hold-off
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= 26);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got.kind = draw_kind_t'(m_tuser);
            got.x = m_tdata[8:0];
            got.y = m_tdata[16:9];
            got.glyph = m_tdata[24:17];
            got.colour = m_tdata[32:25];
            got.cx = m_tdata[41:33];
            got.cy = m_tdata[49:42];
            got.last = m_tlast;
            beats_checked++;
            if (pending_draws.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected draw beat kind %0d x %0d y %0d", got.kind, got.x,
                             got.y);
            end
            else
            begin
                want = pending_draws.pop_front();
                if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y
                    || got.glyph !== want.glyph || got.colour !== want.colour
                    || got.cx !== want.cx || got.cy !== want.cy || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $display("exp kind %0d x %0d y %0d glyph %0d col %0d cur %0d,%0d last %0d",
                                 want.kind, want.x, want.y, want.glyph, want.colour,
                                 want.cx, want.cy, want.last);
                        $display("got kind %0d x %0d y %0d glyph %0d col %0d cur %0d,%0d last %0d",
                                 got.kind, got.x, got.y, got.glyph, got.colour,
                                 got.cx, got.cy, got.last);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout with %0d draws outstanding", pending_draws.size());
            $display("FAIL text_console_cursor_engine");
            $finish;
        end
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/tcce_pkg.sv
rtl/core/tcce_modulo.sv
rtl/core/tcce_sequencer.sv
rtl/core/text_console_cursor_engine.sv
tb/sv/testbench.sv
